/* sv/xfsc_pkg.sv */
// ----------------------------------------------------------------------------
// xfsc_pkg: shared types and constants of the XOR float stream compressor
// Code item passed from classifier to byte packer, result item, code kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package xfsc_pkg;

    localparam int unsigned VALUE_W   = 64;   // sample width
    localparam int unsigned CODE_W    = 77;   // longest code: 2+5+6+64
    localparam int unsigned LEN_W     = 7;    // code / buffer bit count
    localparam int unsigned PEND_W    = 7;    // bits held back between items
    localparam int unsigned BUF_W     = 88;   // pending bits plus one code
    localparam int unsigned TOTAL_W   = 32;   // saturating series bit total
    localparam int unsigned LEAD_W    = 5;    // leading count field
    localparam int unsigned MLEN_W    = 6;    // meaningful length - 1 field
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] HDR_WINDOW = 2'b10;
    localparam logic [1:0] HDR_NEW    = 2'b11;
    localparam logic [LEAD_W-1:0] LEAD_MAX = 5'd31;

    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_ZERO,
        KIND_WINDOW,
        KIND_NEW
    } code_kind_t;

    // One classified item: code bits left aligned, zero below len.
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
        logic               series_start;
        logic               series_end;
        logic [TOTAL_W-1:0] total;
    } code_item_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [3:0]         valid_bits;
        logic               run_last;
        logic               stream_end;
        logic [TOTAL_W-1:0] series_bit_total;
    } result_t;

endpackage

`default_nettype wire

/* sv/xfsc_front.sv */
// ----------------------------------------------------------------------------
// xfsc_front: item classifier
// Three stages: XOR and per-byte zero counts, code decision with window and
// bit total update, code assembly. One code item per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module xfsc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [xfsc_pkg::VALUE_W-1:0] value_bits,
    input  logic                         series_start,
    input  logic                         series_end,
    output logic                         item_valid,
    input  logic                         item_ready,
    output xfsc_pkg::code_item_t         item
);

    logic accept;
    logic s1_fire;
    logic s2_fire;
    logic s2_ready;
    logic s3_ready;

    logic [xfsc_pkg::VALUE_W-1:0] prev_reg;
    logic [xfsc_pkg::VALUE_W-1:0] x_c;

    // stage 1
    logic                         s1_valid_reg, s1_valid_next;
    logic [xfsc_pkg::VALUE_W-1:0] s1_data_reg, s1_data_next;
    logic                         s1_start_reg, s1_end_reg;
    logic [7:0]                   s1_nz_reg, s1_nz_next;
    logic [3:0]                   s1_lz_reg [8];
    logic [3:0]                   s1_lz_next [8];
    logic [3:0]                   s1_tz_reg [8];
    logic [3:0]                   s1_tz_next [8];

    // series state
    logic [xfsc_pkg::LEAD_W-1:0]  wl_reg, wl_next;
    logic [xfsc_pkg::MLEN_W-1:0]  wt_reg, wt_next;
    logic [xfsc_pkg::TOTAL_W-1:0] total_reg, total_next;

    // stage 2 decision
    logic [6:0]                   lead_c, trail_c, win_sum_c, m_c, wm_c;
    logic                         fits_c;
    logic [xfsc_pkg::LEAD_W-1:0]  al_c;
    xfsc_pkg::code_kind_t         kind_c;
    logic [xfsc_pkg::LEN_W-1:0]   len_c;
    logic [xfsc_pkg::LEAD_W-1:0]  shamt_c;
    logic [xfsc_pkg::TOTAL_W-1:0] base_c;
    logic [xfsc_pkg::TOTAL_W:0]   sum_c;
    logic [xfsc_pkg::TOTAL_W-1:0] tot_c;

    logic                         s2_valid_reg, s2_valid_next;
    xfsc_pkg::code_kind_t         s2_kind_reg;
    logic [xfsc_pkg::VALUE_W-1:0] s2_data_reg;
    logic [xfsc_pkg::LEAD_W-1:0]  s2_shamt_reg;
    logic [xfsc_pkg::LEAD_W-1:0]  s2_al_reg;
    logic [xfsc_pkg::MLEN_W-1:0]  s2_mm1_reg;
    logic [xfsc_pkg::LEN_W-1:0]   s2_len_reg;
    logic                         s2_start_reg, s2_end_reg;
    logic [xfsc_pkg::TOTAL_W-1:0] s2_total_reg;

    // stage 3 assembly
    logic [xfsc_pkg::VALUE_W-1:0] shifted_c;
    logic [xfsc_pkg::CODE_W-1:0]  code_c;
    logic                         s3_valid_reg, s3_valid_next;
    xfsc_pkg::code_item_t         s3_item_reg, s3_item_next;

    assign s3_ready = !s3_valid_reg || item_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign accept   = in_valid && in_ready;
    assign s1_fire  = s1_valid_reg && s2_ready;
    assign s2_fire  = s2_valid_reg && s3_ready;

    assign item_valid = s3_valid_reg;
    assign item       = s3_item_reg;

    // ---------------- stage 1: XOR and byte-wise zero counts ----------------
    assign x_c          = value_bits ^ prev_reg;
    assign s1_data_next = series_start ? value_bits : x_c;

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            s1_nz_next[j] = |x_c[8*j +: 8];
            s1_lz_next[j] = 4'd8;
            s1_tz_next[j] = 4'd8;
            for (int k = 0; k < 8; k++)
            begin
                if (x_c[8*j + k])
                begin
                    s1_lz_next[j] = 4'(7 - k);
                end
            end
            for (int k = 7; k >= 0; k--)
            begin
                if (x_c[8*j + k])
                begin
                    s1_tz_next[j] = 4'(k);
                end
            end
        end
    end

    assign s1_valid_next = accept || (s1_valid_reg && !s2_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                prev_reg <= value_bits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg  <= s1_data_next;
            s1_start_reg <= series_start;
            s1_end_reg   <= series_end;
            s1_nz_reg    <= s1_nz_next;
            s1_lz_reg    <= s1_lz_next;
            s1_tz_reg    <= s1_tz_next;
        end
    end

    // ---------------- stage 2: decide code, update window -------------------
    always_comb
    begin
        lead_c = 7'd64;
        for (int j = 0; j < 8; j++)
        begin
            if (s1_nz_reg[j])
            begin
                lead_c = 7'((7 - j) * 8) + {3'b000, s1_lz_reg[j]};
            end
        end
        trail_c = 7'd64;
        for (int j = 7; j >= 0; j--)
        begin
            if (s1_nz_reg[j])
            begin
                trail_c = 7'(j * 8) + {3'b000, s1_tz_reg[j]};
            end
        end
    end

    assign win_sum_c = {2'b00, wl_reg} + {1'b0, wt_reg};
    assign wm_c      = 7'd64 - win_sum_c;
    assign fits_c    = (lead_c >= {2'b00, wl_reg}) && (trail_c >= {1'b0, wt_reg})
                       && (win_sum_c < 7'd64);
    assign al_c      = (lead_c > {2'b00, xfsc_pkg::LEAD_MAX}) ? xfsc_pkg::LEAD_MAX
                                                             : lead_c[4:0];
    assign m_c       = 7'd64 - {2'b00, al_c} - trail_c;

    always_comb
    begin
        if (s1_start_reg)
        begin
            kind_c = xfsc_pkg::KIND_RAW;
        end
        else if (~|s1_nz_reg)
        begin
            kind_c = xfsc_pkg::KIND_ZERO;
        end
        else if (fits_c)
        begin
            kind_c = xfsc_pkg::KIND_WINDOW;
        end
        else
        begin
            kind_c = xfsc_pkg::KIND_NEW;
        end
    end

    always_comb
    begin
        unique case (kind_c)
            xfsc_pkg::KIND_RAW:
            begin
                len_c   = 7'd64;
                shamt_c = '0;
            end
            xfsc_pkg::KIND_ZERO:
            begin
                len_c   = 7'd1;
                shamt_c = '0;
            end
            xfsc_pkg::KIND_WINDOW:
            begin
                len_c   = 7'd2 + wm_c;
                shamt_c = wl_reg;
            end
            xfsc_pkg::KIND_NEW:
            begin
                len_c   = 7'd13 + m_c;
                shamt_c = al_c;
            end
            default:
            begin
                len_c   = '0;
                shamt_c = '0;
            end
        endcase
    end

    // saturating bit total, cleared by a series start
    assign base_c = s1_start_reg ? '0 : total_reg;
    assign sum_c  = {1'b0, base_c} + 33'(len_c);
    assign tot_c  = sum_c[xfsc_pkg::TOTAL_W] ? '1 : sum_c[xfsc_pkg::TOTAL_W-1:0];

    always_comb
    begin
        wl_next    = wl_reg;
        wt_next    = wt_reg;
        total_next = total_reg;
        if (s1_fire)
        begin
            total_next = tot_c;
            if (s1_start_reg)
            begin
                wl_next = '0;
                wt_next = '0;
            end
            else if (kind_c == xfsc_pkg::KIND_NEW)
            begin
                wl_next = al_c;
                wt_next = trail_c[5:0];
            end
        end
    end

    assign s2_valid_next = s1_fire || (s2_valid_reg && !s3_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg       <= '0;
            wt_reg       <= '0;
            total_reg    <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            wl_reg       <= wl_next;
            wt_reg       <= wt_next;
            total_reg    <= total_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_kind_reg  <= kind_c;
            s2_data_reg  <= s1_data_reg;
            s2_shamt_reg <= shamt_c;
            s2_al_reg    <= al_c;
            s2_mm1_reg   <= 6'(m_c - 7'd1);
            s2_len_reg   <= len_c;
            s2_start_reg <= s1_start_reg;
            s2_end_reg   <= s1_end_reg;
            s2_total_reg <= tot_c;
        end
    end

    // ---------------- stage 3: assemble left-aligned code -------------------
    // Shifting out the leading zeros leaves the meaningful bits on top; the
    // bits below them are the XOR's trailing zeros.
    assign shifted_c = s2_data_reg << s2_shamt_reg;

    always_comb
    begin
        unique case (s2_kind_reg)
            xfsc_pkg::KIND_RAW:    code_c = {s2_data_reg, 13'b0};
            xfsc_pkg::KIND_ZERO:   code_c = '0;
            xfsc_pkg::KIND_WINDOW: code_c = {xfsc_pkg::HDR_WINDOW, shifted_c, 11'b0};
            xfsc_pkg::KIND_NEW:    code_c = {xfsc_pkg::HDR_NEW, s2_al_reg, s2_mm1_reg,
                                             shifted_c};
            default:               code_c = '0;
        endcase
    end

    always_comb
    begin
        s3_item_next.code         = code_c;
        s3_item_next.len          = s2_len_reg;
        s3_item_next.series_start = s2_start_reg;
        s3_item_next.series_end   = s2_end_reg;
        s3_item_next.total        = s2_total_reg;
    end

    assign s3_valid_next = s2_fire || (s3_valid_reg && !item_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

endmodule

`default_nettype wire

/* sv/xfsc_fifo.sv */
// ----------------------------------------------------------------------------
// xfsc_fifo: code item queue
// Short register queue between classifier and byte packer.
// ----------------------------------------------------------------------------
`default_nettype none

module xfsc_fifo #(
    parameter int unsigned DEPTH = xfsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  xfsc_pkg::code_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_pop,
    output xfsc_pkg::code_item_t rd_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    xfsc_pkg::code_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg != CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

/* sv/xfsc_back.sv */
// ----------------------------------------------------------------------------
// xfsc_back: byte packer
// Merges held-back bits with one code item and sends one byte per cycle
// through a result register when free; pads and flushes at series end.
// ----------------------------------------------------------------------------
`default_nettype none

module xfsc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_pop,
    input  xfsc_pkg::code_item_t item,
    output logic                 res_valid,
    input  logic                 res_pop,
    output xfsc_pkg::result_t    res
);

    localparam int unsigned BW = xfsc_pkg::BUF_W;
    localparam int unsigned PW = xfsc_pkg::PEND_W;

    logic                         busy_reg, busy_next;
    logic [BW-1:0]                buf_reg, buf_next;
    logic [xfsc_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic                         end_reg, end_next;
    logic [xfsc_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [PW-1:0]                pend_reg, pend_next;   // left aligned
    logic [2:0]                   pcnt_reg, pcnt_next;

    logic                         res_valid_reg;
    xfsc_pkg::result_t            res_reg, res_next;
    logic                         slot_free;
    logic                         out_load;

    logic [2:0]                   pc_c;
    logic [PW-1:0]                pb_c;
    logic [BW-1:0]                ld_buf_c;
    logic [xfsc_pkg::LEN_W-1:0]   ld_rem_c;
    logic [BW-1:0]                em_buf_c;
    logic [xfsc_pkg::LEN_W-1:0]   em_rem_c;

    function automatic logic has_byte(input logic [xfsc_pkg::LEN_W-1:0] r, input logic e);
        return (r >= 7'd8) || (e && (r != '0));
    endfunction

    assign slot_free = !res_valid_reg || res_pop;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a series start drops whatever was held back
    assign pc_c     = item.series_start ? 3'd0 : pcnt_reg;
    assign pb_c     = item.series_start ? '0 : pend_reg;
    assign ld_buf_c = {pb_c, {(BW-PW){1'b0}}} | ({item.code, 11'b0} >> pc_c);
    assign ld_rem_c = {4'b0000, pc_c} + item.len;

    // byte at the top of the buffer
    always_comb
    begin
        res_next.out_byte         = buf_reg[BW-1 -: 8];
        res_next.series_bit_total = total_reg;
        em_buf_c                  = buf_reg << 8;
        if (rem_reg >= 7'd8)
        begin
            res_next.valid_bits = 4'd8;
            res_next.run_last   = end_reg ? (rem_reg == 7'd8) : (rem_reg < 7'd16);
            res_next.stream_end = end_reg && (rem_reg == 7'd8);
            em_rem_c            = rem_reg - 7'd8;
        end
        else
        begin
            // final padded byte
            res_next.valid_bits = rem_reg[3:0];
            res_next.run_last   = 1'b1;
            res_next.stream_end = 1'b1;
            em_rem_c            = '0;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        buf_next   = buf_reg;
        rem_next   = rem_reg;
        end_next   = end_reg;
        total_next = total_reg;
        pend_next  = pend_reg;
        pcnt_next  = pcnt_reg;
        item_pop   = 1'b0;
        out_load   = 1'b0;
        if (!busy_reg)
        begin
            if (item_valid)
            begin
                item_pop   = 1'b1;
                buf_next   = ld_buf_c;
                rem_next   = ld_rem_c;
                end_next   = item.series_end;
                total_next = item.total;
                if (has_byte(ld_rem_c, item.series_end))
                begin
                    busy_next = 1'b1;
                end
                else
                begin
                    pend_next = ld_buf_c[BW-1 -: PW];
                    pcnt_next = ld_rem_c[2:0];
                end
            end
        end
        else if (slot_free)
        begin
            out_load = 1'b1;
            buf_next = em_buf_c;
            rem_next = em_rem_c;
            if (!has_byte(em_rem_c, end_reg))
            begin
                busy_next = 1'b0;
                if (end_reg)
                begin
                    pend_next = '0;
                    pcnt_next = '0;
                end
                else
                begin
                    pend_next = em_buf_c[BW-1 -: PW];
                    pcnt_next = em_rem_c[2:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rem_reg       <= '0;
            end_reg       <= 1'b0;
            pend_reg      <= '0;
            pcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
            end_reg  <= end_next;
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        total_reg <= total_next;
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

/* sv/xor_float_stream_compressor.sv */
// ----------------------------------------------------------------------------
// xor_float_stream_compressor: XOR coding of 64-bit float samples to bytes
// Classifier pipeline, code item queue and byte packer.
// ----------------------------------------------------------------------------
// Takes one 64-bit sample per item and writes its XOR code MSB first as a
// byte stream. A series start writes the raw 64 bits; a repeat writes a
// single 0; otherwise '10' plus the stored window bits, or '11', a 5-bit
// leading count (clamped to 31, length widened to match), a 6-bit length
// minus one and the meaningful bits. A series end pads the last byte with
// zeros and flags it with stream_end and a valid_bits count below 8 when
// partial. Every byte carries the saturating unpadded bit total of its
// series so far; run_last marks the last byte that an item caused. Items
// that only add bits to a partial byte produce no result at all.
// The input side takes an item every cycle unless full, into a three-stage
// classifier feeding a QUEUE_DEPTH-entry queue. The byte packer sets the
// rate: it loads an item, then sends the bytes it completes, one per cycle
// while the output register is free, taking no new item meanwhile. A 77-bit
// code plus held-back bits and a flush yield up to 11 bytes, a raw sample
// 8. Results wait in a one-entry output register, drained by pop.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_float_stream_compressor #(
    parameter int unsigned QUEUE_DEPTH = xfsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input queue side
    input  logic                         push,
    output logic                         full,
    input  logic [xfsc_pkg::VALUE_W-1:0] value_bits,
    input  logic                         series_start,
    input  logic                         series_end,
    // result queue side
    output logic                         empty,
    input  logic                         pop,
    output logic [7:0]                   out_byte,
    output logic [3:0]                   valid_bits,
    output logic                         run_last,
    output logic                         stream_end,
    output logic [xfsc_pkg::TOTAL_W-1:0] series_bit_total
);

    logic                 in_ready;
    logic                 fr_valid;
    logic                 fr_ready;
    xfsc_pkg::code_item_t fr_item;
    logic                 q_valid;
    logic                 q_pop;
    xfsc_pkg::code_item_t q_item;
    logic                 res_valid;
    xfsc_pkg::result_t    res;

    assign full = !in_ready;

    // classifier: XOR, zero counts, window decision, code assembly
    xfsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (push),
        .in_ready     (in_ready),
        .value_bits   (value_bits),
        .series_start (series_start),
        .series_end   (series_end),
        .item_valid   (fr_valid),
        .item_ready   (fr_ready),
        .item         (fr_item)
    );

    // decouples the one-item-per-cycle classifier from the byte-rate packer
    xfsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_item  (fr_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    // packer: held-back bits + code; a byte per free cycle; pad at series end
    xfsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .item       (q_item),
        .res_valid  (res_valid),
        .res_pop    (pop),
        .res        (res)
    );

    assign empty            = !res_valid;
    assign out_byte         = res.out_byte;
    assign valid_bits       = res.valid_bits;
    assign run_last         = res.run_last;
    assign stream_end       = res.stream_end;
    assign series_bit_total = res.series_bit_total;

endmodule

`default_nettype wire

/* sv/xfsc_checker.sv */
// ----------------------------------------------------------------------------
// xfsc_checker: port-level checks of the compressor
// Result framing rules and output hold; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xfsc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic [7:0]                   out_byte,
    input logic [3:0]                   valid_bits,
    input logic                         run_last,
    input logic                         stream_end,
    input logic [xfsc_pkg::TOTAL_W-1:0] series_bit_total
);

    // a byte carries 1 to 8 bits
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (valid_bits >= 4'd1) && (valid_bits <= 4'd8))
        else $error("valid_bits out of range");

    // only the padded byte at a series end is partial
    a_partial_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (valid_bits != 4'd8)) |-> (stream_end && run_last))
        else $error("partial byte not at series end");

    // the series end byte closes its item
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_end) |-> run_last)
        else $error("stream_end without run_last");

    // a result not taken holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte)
                              && $stable(series_bit_total)))
        else $error("result changed while waiting");

endmodule

bind xor_float_stream_compressor xfsc_checker u_xfsc_checker (.*);

`default_nettype wire
